// ===== design/hash_interval_record_decoder_assert.svh =====
// assertion macros for the interval record decoder
`ifndef HASH_INTERVAL_RECORD_DECODER_ASSERT_SVH
`define HASH_INTERVAL_RECORD_DECODER_ASSERT_SVH
`ifndef SYNTH
`define HIRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hird assertion failed");
`define HIRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hird assertion failed");
`else
`define HIRD_ASSERT_IMP(lbl, ante, cons)
`define HIRD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/hird_pkg.sv =====
// types and constants shared by the interval record decoder
`default_nettype none
package hird_pkg;

  localparam logic [2:0] REC_S   = 3'd0;
  localparam logic [2:0] REC_L   = 3'd1;
  localparam logic [2:0] REC_SL  = 3'd2;
  localparam logic [2:0] REC_SLE = 3'd3;

  typedef struct packed {
    logic [2:0]  record_type;
    logic        msb_flag;
    logic        carry_flag;
    logic [23:0] payload;
    logic        last_record;
  } rec_t;

  typedef struct packed {
    logic [31:0] d_start;
    logic [31:0] d_length;
    logic [2:0]  rec_type;
    logic        msb;
    logic [7:0]  exlift;
    logic        type_err;
    logic        last;
  } part_t;

  typedef struct packed {
    logic [31:0] interval_start;
    logic [31:0] interval_length;
    logic [7:0]  extra_liftover;
    logic        combo_valid;
    logic        type_error;
  } result_t;

endpackage
`default_nettype wire

// ===== design/hird_if.sv =====
// record and result channel interfaces
`default_nettype none
interface hird_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_type;
  logic        msb_flag;
  logic        carry_flag;
  logic [23:0] payload;
  logic        last_record;

  modport source (output valid, record_type, msb_flag, carry_flag, payload, last_record,
                  input ready);
  modport sink (input valid, record_type, msb_flag, carry_flag, payload, last_record,
                output ready);
endinterface

interface hird_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] interval_start;
  logic [31:0] interval_length;
  logic [7:0]  extra_liftover;
  logic        combo_valid;
  logic        type_error;

  modport source (output valid, interval_start, interval_length, extra_liftover,
                  combo_valid, type_error, input ready);
  modport sink (input valid, interval_start, interval_length, extra_liftover,
                combo_valid, type_error, output ready);
endinterface
`default_nettype wire

// ===== design/hird_part.sv =====
// per-record start and length parts from payload slices
`default_nettype none
module hird_part (
  input  hird_pkg::rec_t  rec,
  output hird_pkg::part_t part
);
  import hird_pkg::*;

  logic [23:0] p;
  logic [7:0]  ex;

  assign p  = rec.payload;
  assign ex = p[23:16];

  always_comb begin
    part.d_start  = 32'd0;
    part.d_length = 32'd0;
    part.type_err = 1'b0;
    part.rec_type = rec.record_type;
    part.msb      = rec.msb_flag;
    part.exlift   = ex;
    part.last     = rec.last_record;
    case (rec.record_type)
      REC_SL: begin
        if (!rec.msb_flag) begin
          part.d_start  = {17'd0, p[14:0]};
          part.d_length = {23'd0, p[23:15]};
        end else begin
          part.d_start  = {p[7:0], 24'd0};
          part.d_length = {16'd0, p[23:8]};
        end
      end
      REC_SLE: begin
        part.d_start  = rec.msb_flag ? {p[7:0], 24'd0} : {24'd0, p[7:0]};
        part.d_length = (ex != 8'd0) ? {24'd0, p[15:8]} : {p[15:8], 24'd0};
      end
      // carry sits just above the 24-bit payload, so no add is needed
      REC_S:   part.d_start  = {7'd0, rec.carry_flag, p};
      REC_L:   part.d_length = {8'd0, p};
      default: part.type_err = 1'b1;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/hird_acc.sv =====
// accumulator state, pattern check and result register
`default_nettype none
module hird_acc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  hird_pkg::part_t   part,
  output logic              s1_go,
  output logic              out_valid,
  input  logic              out_ready,
  output hird_pkg::result_t result
);
  import hird_pkg::*;

  logic [31:0] start_r, length_r;
  logic [31:0] start_nxt, length_nxt;
  logic [1:0]  count_r;
  logic [2:0]  first_type_r, first_type_nxt;
  logic        first_msb_r, first_msb_nxt;
  logic [7:0]  first_ex_r, first_ex_nxt;
  logic [2:0]  second_type_r, second_type_nxt;
  logic        err_r, err_nxt;
  logic        too_many_r;
  logic        out_valid_r;
  result_t     result_r;
  logic        ok;
  logic        step;

  // a non-last record never needs the result slot, so it always moves on
  assign s1_go     = !(s1_valid && part.last) || !out_valid_r || out_ready;
  assign step      = s1_valid && s1_go;
  assign out_valid = out_valid_r;
  assign result    = result_r;

  always_comb begin
    start_nxt       = start_r + part.d_start;
    length_nxt      = length_r + part.d_length;
    first_type_nxt  = (count_r == 2'd0) ? part.rec_type : first_type_r;
    first_msb_nxt   = (count_r == 2'd0) ? part.msb : first_msb_r;
    first_ex_nxt    = (count_r == 2'd0) ? part.exlift : first_ex_r;
    second_type_nxt = (count_r == 2'd1) ? part.rec_type : second_type_r;
    err_nxt         = err_r | part.type_err;
  end

  always_comb begin
    ok = 1'b0;
    if (!too_many_r) begin
      case (count_r)
        2'd0: ok = (first_type_nxt == REC_SL && !first_msb_nxt) ||
                   (first_type_nxt == REC_SLE && first_ex_nxt != 8'd0 && !first_msb_nxt);
        2'd1: ok = (first_type_nxt == REC_SL && first_msb_nxt && second_type_nxt == REC_S) ||
                   (first_type_nxt == REC_SLE && first_ex_nxt != 8'd0 && first_msb_nxt &&
                    second_type_nxt == REC_S) ||
                   (first_type_nxt == REC_SLE && first_ex_nxt == 8'd0 && !first_msb_nxt &&
                    second_type_nxt == REC_L) ||
                   (first_type_nxt == REC_S && second_type_nxt == REC_L);
        2'd2: ok = first_type_nxt == REC_SLE && first_ex_nxt == 8'd0 && first_msb_nxt &&
                   second_type_nxt == REC_S && part.rec_type == REC_L;
        default: ok = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= 32'd0;
      length_r      <= 32'd0;
      count_r       <= 2'd0;
      first_type_r  <= REC_S;
      first_msb_r   <= 1'b0;
      first_ex_r    <= 8'd0;
      second_type_r <= REC_S;
      err_r         <= 1'b0;
      too_many_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (step && part.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (step) begin
        if (part.last) begin
          start_r       <= 32'd0;
          length_r      <= 32'd0;
          count_r       <= 2'd0;
          first_type_r  <= REC_S;
          first_msb_r   <= 1'b0;
          first_ex_r    <= 8'd0;
          second_type_r <= REC_S;
          err_r         <= 1'b0;
          too_many_r    <= 1'b0;
        end else begin
          start_r       <= start_nxt;
          length_r      <= length_nxt;
          first_type_r  <= first_type_nxt;
          first_msb_r   <= first_msb_nxt;
          first_ex_r    <= first_ex_nxt;
          second_type_r <= second_type_nxt;
          err_r         <= err_nxt;
          if (count_r == 2'd3) begin
            too_many_r <= 1'b1;
          end else begin
            count_r <= count_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && part.last) begin
      result_r.interval_start  <= start_nxt;
      result_r.interval_length <= length_nxt;
      result_r.extra_liftover  <= (first_type_nxt == REC_SLE) ? first_ex_nxt : 8'd0;
      result_r.combo_valid     <= ok;
      result_r.type_error      <= err_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/hash_interval_record_decoder.sv =====
// top level of the interval record decoder
`default_nettype none
`include "hash_interval_record_decoder_assert.svh"
// Interval record decoder. Records stream in one per cycle while no last record
// waits on the result register; each goes through an input register, then its
// start and length parts are added into two 32-bit accumulators. A record marked
// last closes the set and its result is loaded into the output register as that
// record leaves the input register. Records that are not last keep flowing while
// a result waits on the output; only a last record waits for the result register
// to free up.
module hash_interval_record_decoder (
  input  logic       clk,
  input  logic       rst_n,
  hird_in_if.sink    in_ch,
  hird_out_if.source out_ch
);
  import hird_pkg::*;

  rec_t    rec_r;
  logic    in_valid_r;
  logic    s1_go;
  part_t   part;
  result_t result;
  logic    out_valid;

  assign in_ch.ready = !in_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      rec_r.record_type <= in_ch.record_type;
      rec_r.msb_flag    <= in_ch.msb_flag;
      rec_r.carry_flag  <= in_ch.carry_flag;
      rec_r.payload     <= in_ch.payload;
      rec_r.last_record <= in_ch.last_record;
    end
  end

  hird_part u_part (
    .rec  (rec_r),
    .part (part)
  );

  hird_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (in_valid_r),
    .part      (part),
    .s1_go     (s1_go),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .result    (result)
  );

  assign out_ch.valid           = out_valid;
  assign out_ch.interval_start  = result.interval_start;
  assign out_ch.interval_length = result.interval_length;
  assign out_ch.extra_liftover  = result.extra_liftover;
  assign out_ch.combo_valid     = result.combo_valid;
  assign out_ch.type_error      = result.type_error;

  // a non-last record in the input register never blocks the input side
  `HIRD_ASSERT_IMP(a_nonlast_flows, in_valid_r && !rec_r.last_record, in_ch.ready)
  // a last record leaving the input register lands a result
  `HIRD_ASSERT_NXT(a_last_gives_result, in_valid_r && rec_r.last_record && s1_go,
                   out_ch.valid)
  // a new result only ever follows a last record
  `HIRD_ASSERT_IMP(a_result_from_last, $rose(out_ch.valid),
                   $past(in_valid_r && rec_r.last_record))
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the interval record decoder
module tb_top;
  import hird_pkg::*;

  localparam int ITEM_TARGET = 1200;
  localparam int CALM_FROM   = 1050;
  localparam int MID_PAUSE   = 600;
  localparam int QUIET_LIMIT = 500;
  localparam int TOO_MANY    = 4;
  localparam logic [2:0] REC_BAD_LO = 3'd4;
  localparam logic [2:0] REC_BAD_HI = 3'd7;
  localparam logic [31:0] START_CARRY = 32'h0100_0000;

  typedef struct {
    rec_t    rec;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  hird_in_if  in_ch ();
  hird_out_if out_ch ();

  hash_interval_record_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // running copy of the decoder state
  logic [31:0] sum_start;
  logic [31:0] sum_length;
  logic [1:0]  held;
  logic [2:0]  lead_type;
  logic        lead_msb;
  logic [7:0]  lead_exlift;
  logic [2:0]  next_type;
  logic        bad_type;
  logic        overflow;

  result_t pending_results[$];
  int      errors = 0;
  int      sent = 0;
  int      quiet = 0;
  bit      calm = 1'b0;

  function automatic void clear_set();
    sum_start   = '0;
    sum_length  = '0;
    held        = '0;
    lead_type   = REC_S;
    lead_msb    = 1'b0;
    lead_exlift = '0;
    next_type   = REC_S;
    bad_type    = 1'b0;
    overflow    = 1'b0;
  endfunction

  function automatic bit legal_set(input int n, input logic [2:0] third_type);
    bit sle_lift;
    bit sle_flat;
    sle_lift = (lead_type == REC_SLE) && (lead_exlift != 8'd0);
    sle_flat = (lead_type == REC_SLE) && (lead_exlift == 8'd0);
    case (n)
      1: return (lead_type == REC_SL && !lead_msb) || (sle_lift && !lead_msb);
      2: return (lead_type == REC_SL && lead_msb && next_type == REC_S) ||
                (sle_lift && lead_msb && next_type == REC_S) ||
                (sle_flat && !lead_msb && next_type == REC_L) ||
                (lead_type == REC_S && next_type == REC_L);
      3: return sle_flat && lead_msb && next_type == REC_S && third_type == REC_L;
      default: return 1'b0;
    endcase
  endfunction

  // folds one record into the sums; returns 1 when the record closes a set
  function automatic bit decode_record(input rec_t r, output result_t res);
    logic [7:0]  ex;
    logic [23:0] p;
    logic [31:0] ds;
    logic [31:0] dl;
    int          n;
    p   = r.payload;
    ex  = p[23:16];
    ds  = '0;
    dl  = '0;
    res = '0;
    case (r.record_type)
      REC_SL: begin
        if (!r.msb_flag) begin
          ds = {17'd0, p[14:0]};
          dl = {23'd0, p[23:15]};
        end else begin
          ds = {p[7:0], 24'd0};
          dl = {16'd0, p[23:8]};
        end
      end
      REC_SLE: begin
        ds = r.msb_flag ? {p[7:0], 24'd0} : {24'd0, p[7:0]};
        dl = (ex != 8'd0) ? {24'd0, p[15:8]} : {p[15:8], 24'd0};
      end
      REC_S: ds = {8'd0, p} + (r.carry_flag ? START_CARRY : 32'd0);
      REC_L: dl = {8'd0, p};
      default: bad_type = 1'b1;
    endcase
    sum_start  = sum_start + ds;
    sum_length = sum_length + dl;
    if (held == 2'd0) begin
      lead_type   = r.record_type;
      lead_msb    = r.msb_flag;
      lead_exlift = ex;
    end else if (held == 2'd1) begin
      next_type = r.record_type;
    end
    if (r.last_record) begin
      n = overflow ? TOO_MANY : int'(held) + 1;
      res.interval_start  = sum_start;
      res.interval_length = sum_length;
      res.extra_liftover  = (lead_type == REC_SLE) ? lead_exlift : 8'd0;
      res.combo_valid     = legal_set(n, r.record_type);
      res.type_error      = bad_type;
      clear_set();
      return 1'b1;
    end
    if (held == 2'd3) overflow = 1'b1;
    else held = held + 2'd1;
    return 1'b0;
  endfunction

  function automatic logic [23:0] rand_payload();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // exl < 0 leaves the exlift byte random
  function automatic rec_t pick(input logic [2:0] t, input bit m, input int exl);
    rec_t r;
    r.record_type = t;
    r.msb_flag    = m;
    r.carry_flag  = 1'($urandom_range(0, 1));
    r.payload     = rand_payload();
    if (exl >= 0) r.payload[23:16] = 8'(exl);
    r.last_record = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t row(input logic [2:0] t, input bit m, input bit c,
                                   input logic [23:0] p, input bit l,
                                   input bit typed = 1'b0,
                                   input logic [31:0] s = '0, input logic [31:0] ln = '0,
                                   input logic [7:0] x = '0, input bit ok = 1'b0,
                                   input bit er = 1'b0);
    dir_row_t d;
    d.rec.record_type        = t;
    d.rec.msb_flag           = m;
    d.rec.carry_flag         = c;
    d.rec.payload            = p;
    d.rec.last_record        = l;
    d.typed                  = typed;
    d.want.interval_start    = s;
    d.want.interval_length   = ln;
    d.want.extra_liftover    = x;
    d.want.combo_valid       = ok;
    d.want.type_error        = er;
    return d;
  endfunction

  task automatic put_record(input rec_t r, input bit typed, input result_t want);
    result_t got;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.record_type <= r.record_type;
    in_ch.msb_flag    <= r.msb_flag;
    in_ch.carry_flag  <= r.carry_flag;
    in_ch.payload     <= r.payload;
    in_ch.last_record <= r.last_record;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (sent >= CALM_FROM) calm = 1'b1;
    if (decode_record(r, got)) pending_results.push_back(typed ? want : got);
  endtask

  // hold the sender off until every outstanding result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  initial begin : stimulus
    dir_row_t rows[$];
    rec_t     batch[$];
    int       pat;
    int       idx;
    bit       mid_pause_done;
    mid_pause_done     = 1'b0;
    clear_set();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.record_type <= REC_S;
    in_ch.msb_flag    <= 1'b0;
    in_ch.carry_flag  <= 1'b0;
    in_ch.payload     <= '0;
    in_ch.last_record <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-record sets at the payload extremes
    rows.push_back(row(REC_SL, 0, 0, 24'hFFFFFF, 1,
                       1, 32'h0000_7FFF, 32'h0000_01FF, 8'h00, 1, 0));
    rows.push_back(row(REC_SLE, 0, 0, 24'h01FFFF, 1,
                       1, 32'h0000_00FF, 32'h0000_00FF, 8'h01, 1, 0));
    // start wraps past 2^32 through the carry
    rows.push_back(row(REC_SL, 1, 0, 24'hFFFFFF, 0));
    rows.push_back(row(REC_S, 0, 1, 24'hFFFFFF, 1,
                       1, 32'h00FF_FFFF, 32'h0000_FFFF, 8'h00, 1, 0));
    rows.push_back(row(REC_SLE, 1, 0, 24'h800001, 0));
    rows.push_back(row(REC_S, 0, 0, 24'h000000, 1));
    rows.push_back(row(REC_SLE, 0, 0, 24'h00ABCD, 0));
    rows.push_back(row(REC_L, 1, 1, 24'h123456, 1));
    rows.push_back(row(REC_S, 0, 0, 24'h000000, 0));
    rows.push_back(row(REC_L, 0, 0, 24'h000000, 1,
                       1, 32'h0000_0000, 32'h0000_0000, 8'h00, 1, 0));
    rows.push_back(row(REC_SLE, 1, 0, 24'h001234, 0));
    rows.push_back(row(REC_S, 1, 1, 24'h000001, 0));
    rows.push_back(row(REC_L, 0, 0, 24'hFFFFFF, 1));
    rows.push_back(row(REC_BAD_HI, 1, 1, 24'hFFFFFF, 1,
                       1, 32'h0000_0000, 32'h0000_0000, 8'h00, 0, 1));
    rows.push_back(row(REC_BAD_LO, 0, 0, 24'h000000, 0));
    rows.push_back(row(REC_SL, 0, 0, 24'h5A5A5A, 1));
    // five records overflow the pattern window
    rows.push_back(row(REC_L, 0, 0, 24'hFFFFFF, 0));
    rows.push_back(row(REC_L, 0, 0, 24'hFFFFFF, 0));
    rows.push_back(row(REC_L, 0, 0, 24'hFFFFFF, 0));
    rows.push_back(row(REC_L, 0, 0, 24'hFFFFFF, 0));
    rows.push_back(row(REC_L, 0, 0, 24'hFFFFFF, 1));
    // leading SLE keeps its exlift even on a broken pattern
    rows.push_back(row(REC_SLE, 0, 0, 24'h05F00F, 0));
    rows.push_back(row(REC_L, 0, 0, 24'h000010, 1));
    rows.push_back(row(REC_SLE, 0, 0, 24'h00FF00, 1));
    foreach (rows[i]) put_record(rows[i].rec, rows[i].typed, rows[i].want);
    wait_drained();

    while (sent < ITEM_TARGET) begin
      batch.delete();
      pat = $urandom_range(0, 8);
      case (pat)
        0: batch.push_back(pick(REC_SL, 1'b0, -1));
        1: batch.push_back(pick(REC_SLE, 1'b0, $urandom_range(1, 255)));
        2: begin
          batch.push_back(pick(REC_SL, 1'b1, -1));
          batch.push_back(pick(REC_S, 1'($urandom_range(0, 1)), -1));
        end
        3: begin
          batch.push_back(pick(REC_SLE, 1'b1, $urandom_range(1, 255)));
          batch.push_back(pick(REC_S, 1'($urandom_range(0, 1)), -1));
        end
        4: begin
          batch.push_back(pick(REC_SLE, 1'b0, 0));
          batch.push_back(pick(REC_L, 1'($urandom_range(0, 1)), -1));
        end
        5: begin
          batch.push_back(pick(REC_S, 1'($urandom_range(0, 1)), -1));
          batch.push_back(pick(REC_L, 1'($urandom_range(0, 1)), -1));
        end
        6: begin
          batch.push_back(pick(REC_SLE, 1'b1, 0));
          batch.push_back(pick(REC_S, 1'($urandom_range(0, 1)), -1));
          batch.push_back(pick(REC_L, 1'($urandom_range(0, 1)), -1));
        end
        default: begin
          repeat ($urandom_range(1, 6))
            batch.push_back(pick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), -1));
        end
      endcase
      // break an otherwise legal set now and then
      if (pat <= 6 && $urandom_range(0, 6) == 0) begin
        idx = $urandom_range(0, batch.size() - 1);
        batch[idx].record_type = 3'($urandom_range(0, 7));
        batch[idx].msb_flag    = batch[idx].msb_flag ^ 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) batch.push_back(pick(REC_L, 1'b0, -1));
      end
      batch[batch.size() - 1].last_record = 1'b1;
      foreach (batch[i]) put_record(batch[i], 1'b0, '0);
      if (!mid_pause_done && sent >= MID_PAUSE) begin
        mid_pause_done = 1'b1;
        wait_drained();
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got start %0h length %0h", $time,
                 out_ch.interval_start, out_ch.interval_length);
      end else begin
        want = pending_results.pop_front();
        check_field("interval_start", want.interval_start, out_ch.interval_start);
        check_field("interval_length", want.interval_length, out_ch.interval_length);
        check_field("extra_liftover", 32'(want.extra_liftover), 32'(out_ch.extra_liftover));
        check_field("combo_valid", 32'(want.combo_valid), 32'(out_ch.combo_valid));
        check_field("type_error", 32'(want.type_error), 32'(out_ch.type_error));
      end
    end
  end

  // stall watchdog: no transaction on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
